>>> src/hierarchical_affine_transform_compose_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the affine transform compose core
// Immediate-consequence and next-cycle property forms, clocked on clk and
// held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_AFFINE_TRANSFORM_COMPOSE_CORE_MACROS_SVH
`define HIERARCHICAL_AFFINE_TRANSFORM_COMPOSE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define HATC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define HATC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HATC_ASSERT_SAME(lbl, ante, cons, msg)
`define HATC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/hatc_pkg.sv
// ----------------------------------------------------------------------------
// hatc_pkg
// Shared command word, operation codes and fixed-point constants of the
// affine transform compose core.
// ----------------------------------------------------------------------------
package hatc_pkg;

    // multiplier operand codes
    localparam logic [3:0] MUL_NONE = 4'd0;
    localparam logic [3:0] MUL_X    = 4'd1;
    localparam logic [3:0] MUL_X2   = 4'd2;
    localparam logic [3:0] MUL_V    = 4'd3;
    localparam logic [3:0] MUL_Q    = 4'd4;
    localparam logic [3:0] MUL_S    = 4'd5;
    localparam logic [3:0] MUL_L    = 4'd6;
    localparam logic [3:0] MUL_C    = 4'd7;

    // writeback codes
    localparam logic [3:0] WB_NONE  = 4'd0;
    localparam logic [3:0] WB_MOD   = 4'd1;
    localparam logic [3:0] WB_X     = 4'd2;
    localparam logic [3:0] WB_CORR  = 4'd3;
    localparam logic [3:0] WB_CFIN  = 4'd4;
    localparam logic [3:0] WB_SC    = 4'd5;
    localparam logic [3:0] WB_L     = 4'd6;
    localparam logic [3:0] WB_LOAD  = 4'd7;
    localparam logic [3:0] WB_ADD   = 4'd8;
    localparam logic [3:0] WB_FINAL = 4'd9;

    // sequencer length
    localparam logic [5:0] LAST_STEP = 6'd51;

    // Q2.30 constants
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;

    typedef struct packed {
        logic       capture;
        logic [3:0] mul_op;
        logic [3:0] mul_idx;
        logic [3:0] wb_op;
        logic [2:0] wb_idx;
        logic       fin_en;
        logic [2:0] fin_idx;
        logic       mem_rd;
        logic       mem_wr;
        logic       load_out;
    } cmd_t;

    // Horner divisors: sine terms first, then cosine terms
    function automatic logic [6:0] horner_k(input logic [2:0] idx);
        logic [6:0] k;
        case (idx)
            3'd0:    k = 7'd72;
            3'd1:    k = 7'd42;
            3'd2:    k = 7'd20;
            3'd3:    k = 7'd6;
            3'd4:    k = 7'd90;
            3'd5:    k = 7'd56;
            3'd6:    k = 7'd30;
            default: k = 7'd12;
        endcase
        return k;
    endfunction

    // reciprocals floor(2^32 / k) for the same divisors
    function automatic logic [29:0] horner_m(input logic [2:0] idx);
        logic [29:0] m;
        case (idx)
            3'd0:    m = 30'd59652323;
            3'd1:    m = 30'd102261126;
            3'd2:    m = 30'd214748364;
            3'd3:    m = 30'd715827882;
            3'd4:    m = 30'd47721858;
            3'd5:    m = 30'd76695844;
            3'd6:    m = 30'd143165576;
            default: m = 30'd357913941;
        endcase
        return m;
    endfunction

endpackage

>>> src/hierarchical_affine_transform_compose_core.sv
// ----------------------------------------------------------------------------
// hierarchical_affine_transform_compose_core
// Builds each node's local 2D affine matrix from angle, scale and position,
// composes a non-root's with the parent's stored global matrix, stores result.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   in       | in_valid / in_stall  | slot_index parent_slot is_root angle
//            |                      | scale_x scale_y pos_x pos_y
//   out      | out_valid / out_stall| out_slot m00 m10 m01 m11 trans_x trans_y
//            |                      | saturated
//
// A request runs through acceptance and 52 sequencer steps, a length set by
// the dependent sine/cosine Horner chain on the one shared 33x33 multiplier
// followed by the local and composition products.
// A new request is accepted in the cycle after the previous result is loaded
// into the output register, even while that result waits to be taken.
// Reset clears the sequencer and output valid; the matrix store is not
// cleared, and a slot never written reads as unknown.
// ----------------------------------------------------------------------------
module hierarchical_affine_transform_compose_core
#(
    parameter int MAX_NODES = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [9:0]          slot_index,
    input  logic [9:0]          parent_slot,
    input  logic                is_root,
    input  logic [15:0]         angle,
    input  logic signed [31:0]  scale_x,
    input  logic signed [31:0]  scale_y,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [9:0]          out_slot,
    output logic signed [31:0]  m00,
    output logic signed [31:0]  m10,
    output logic signed [31:0]  m01,
    output logic signed [31:0]  m11,
    output logic signed [31:0]  trans_x,
    output logic signed [31:0]  trans_y,
    output logic                saturated
);

    hatc_pkg::cmd_t cmd;

    // sequencer
    hatc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // arithmetic and store
    hatc_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp
    (
        .clk         (clk),
        .cmd         (cmd),
        .slot_index  (slot_index),
        .parent_slot (parent_slot),
        .is_root     (is_root),
        .angle       (angle),
        .scale_x     (scale_x),
        .scale_y     (scale_y),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .out_slot    (out_slot),
        .m00         (m00),
        .m10         (m10),
        .m01         (m01),
        .m11         (m11),
        .trans_x     (trans_x),
        .trans_y     (trans_y),
        .saturated   (saturated)
    );

endmodule

>>> src/hatc_ctrl.sv
// ----------------------------------------------------------------------------
// hatc_ctrl
// Request handshake and step sequencer; while running, issues one command word
// per cycle to the datapath; the last step waits while the output is full.
// ----------------------------------------------------------------------------
`include "hierarchical_affine_transform_compose_core_macros.svh"

module hatc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output hatc_pkg::cmd_t   cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic       state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;
    hatc_pkg::cmd_t step_word;

    // decode one sequencer step
    function automatic hatc_pkg::cmd_t step_cmd(input logic [5:0] s);
        hatc_pkg::cmd_t c;
        c = '0;
        unique case (s) inside
            6'd0:
            begin
                c.mul_op = hatc_pkg::MUL_X;
                c.wb_op  = hatc_pkg::WB_MOD;
            end
            6'd1:
            begin
                c.wb_op  = hatc_pkg::WB_X;
                c.mem_rd = 1'b1;
            end
            6'd2:  c.mul_op = hatc_pkg::MUL_X2;
            6'd3, 6'd6, 6'd9, 6'd12, 6'd16, 6'd19, 6'd22, 6'd25, 6'd28:
                c.mul_op = hatc_pkg::MUL_V;
            6'd4, 6'd7, 6'd10, 6'd13, 6'd17, 6'd20, 6'd23, 6'd26:
                c.mul_op = hatc_pkg::MUL_Q;
            6'd5, 6'd8, 6'd11, 6'd14, 6'd18, 6'd21, 6'd24, 6'd27:
                c.wb_op = hatc_pkg::WB_CORR;
            6'd15: c.mul_op = hatc_pkg::MUL_S;
            6'd29: c.wb_op  = hatc_pkg::WB_CFIN;
            6'd30: c.wb_op  = hatc_pkg::WB_SC;
            6'd31:
            begin
                c.mul_op  = hatc_pkg::MUL_L;
                c.mul_idx = 4'd0;
            end
            6'd32, 6'd33, 6'd34:
            begin
                c.mul_op  = hatc_pkg::MUL_L;
                c.mul_idx = 4'(s - 6'd31);
                c.wb_op   = hatc_pkg::WB_L;
                c.wb_idx  = 3'(s - 6'd32);
            end
            6'd35:
            begin
                c.wb_op  = hatc_pkg::WB_L;
                c.wb_idx = 3'd3;
            end
            6'd50: c.wb_op = hatc_pkg::WB_FINAL;
            6'd51:
            begin
                c.mem_wr   = 1'b1;
                c.load_out = 1'b1;
            end
            default: c.mul_op = hatc_pkg::MUL_NONE;
        endcase

        // Horner divisor select: sine terms, then cosine terms
        unique case (s) inside
            6'd4, 6'd5:   c.mul_idx = 4'd0;
            6'd7, 6'd8:   c.mul_idx = 4'd1;
            6'd10, 6'd11: c.mul_idx = 4'd2;
            6'd13, 6'd14: c.mul_idx = 4'd3;
            6'd17, 6'd18: c.mul_idx = 4'd4;
            6'd20, 6'd21: c.mul_idx = 4'd5;
            6'd23, 6'd24: c.mul_idx = 4'd6;
            6'd26, 6'd27: c.mul_idx = 4'd7;
            default:      c.mul_idx = c.mul_idx;
        endcase

        // composition: one product a cycle, pairs summed, then clamped
        if (s >= 6'd36 && s <= 6'd47)
        begin
            c.mul_op  = hatc_pkg::MUL_C;
            c.mul_idx = 4'(s - 6'd36);
        end
        if (s >= 6'd37 && s <= 6'd47 && s[0])
            c.wb_op = hatc_pkg::WB_LOAD;
        if (s >= 6'd38 && s <= 6'd48 && !s[0])
            c.wb_op = hatc_pkg::WB_ADD;
        if (s >= 6'd39 && s <= 6'd49 && s[0])
        begin
            c.fin_en  = 1'b1;
            c.fin_idx = 3'((s - 6'd39) >> 1);
        end
        return c;
    endfunction

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign step_word = step_cmd(step_reg);

    // issue the step command; hold the last step while the output is full
    always_comb
    begin
        cmd         = '0;
        cmd.capture = accept;
        state_next  = state_reg;
        step_next   = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    step_next  = 6'd0;
                end
            end
            ST_RUN:
            begin
                if (step_reg == hatc_pkg::LAST_STEP)
                begin
                    if (out_free)
                    begin
                        cmd        = step_word;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd       = step_word;
                    step_next = step_reg + 6'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output valid: set on load, drop on take
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `HATC_ASSERT_NEXT(a_start, in_valid && !in_stall, state_reg == ST_RUN && step_reg == 6'd0, "request accepted but sequencer did not start")
    `HATC_ASSERT_SAME(a_step_range, state_reg == ST_RUN, step_reg <= hatc_pkg::LAST_STEP, "step counter past last step")
    `HATC_ASSERT_SAME(a_load_free, cmd.load_out, !out_valid_reg || !out_stall, "result loaded over a pending result")

endmodule

>>> src/hatc_dp.sv
// ----------------------------------------------------------------------------
// hatc_dp
// Datapath: shared multiplier, sine/cosine Horner registers, local and
// global matrix registers, and the global matrix store.
// ----------------------------------------------------------------------------
module hatc_dp
#(
    parameter int MAX_NODES = 1024
)
(
    input  logic                clk,
    input  hatc_pkg::cmd_t      cmd,
    input  logic [9:0]          slot_index,
    input  logic [9:0]          parent_slot,
    input  logic                is_root,
    input  logic [15:0]         angle,
    input  logic signed [31:0]  scale_x,
    input  logic signed [31:0]  scale_y,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    output logic [9:0]          out_slot,
    output logic signed [31:0]  m00,
    output logic signed [31:0]  m10,
    output logic signed [31:0]  m01,
    output logic signed [31:0]  m11,
    output logic signed [31:0]  trans_x,
    output logic signed [31:0]  trans_y,
    output logic                saturated
);

    localparam int AW      = $clog2(MAX_NODES);
    localparam int MOD_MUL = (1 << 20) / MAX_NODES;

    // captured request
    logic [9:0]         slot_raw_reg, par_raw_reg;
    logic               root_reg, swap_reg;
    logic [1:0]         quad_reg;
    logic [13:0]        rf_reg;
    logic signed [31:0] sx_reg, sy_reg, px_reg, py_reg;

    // addresses
    logic [9:0]         slot_mod_reg;
    logic [AW-1:0]      par_addr_reg;
    logic [16:0]        slot_ext;

    // sine/cosine working registers
    logic [29:0]        x_reg, x2_reg, v_reg, q0_reg, s_reg;
    logic [30:0]        t_reg, c_reg;
    logic signed [17:0] sn_reg, cs_reg;

    // multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mres, prod_reg;

    // local matrix, composition
    logic signed [31:0] loc_reg [4];
    logic signed [31:0] comp_reg [6];
    logic signed [31:0] res_reg [6];
    logic               loc_flag_reg, comp_flag_reg, res_flag_reg;
    logic signed [65:0] acc_reg;
    logic signed [49:0] rnd_reg;

    // store
    logic [191:0]       mem [MAX_NODES];
    logic [191:0]       par_reg;
    logic signed [31:0] p00, p10, p01, p11, ptx, pty;

    // output register
    logic [9:0]         out_slot_reg;
    logic signed [31:0] out_m_reg [6];
    logic               out_flag_reg;

    // writeback helpers
    logic [6:0]         k_val;
    logic [36:0]        qk;
    logic [30:0]        rem, qv;
    logic [16:0]        bs, bc, bs_sw, bc_sw;
    logic signed [65:0] rl, sum;
    logic signed [50:0] fin_v;
    logic signed [31:0] fin_add;
    logic signed [32:0] l_sat, fin_sat;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] val;
    } sat_t;

    sat_t l_res, f_res;

    // slot modulo node count: reciprocal estimate, one correction
    function automatic logic [16:0] mod_nodes(input logic [9:0] v);
        logic [29:0] prod;
        logic [9:0]  q0;
        logic [26:0] qn;
        logic [16:0] r;
        prod = 30'(v) * 30'(MOD_MUL);
        q0   = prod[29:20];
        qn   = 27'(q0) * 27'(MAX_NODES);
        r    = 17'(27'(v) - qn);
        if (r >= 17'(MAX_NODES))
            r = r - 17'(MAX_NODES);
        return r;
    endfunction

    // clamp to signed 32 bits
    function automatic sat_t sat32(input logic signed [50:0] v);
        sat_t o;
        o.hit = 1'b0;
        o.val = v[31:0];
        if (v > 51'sd2147483647)
        begin
            o.hit = 1'b1;
            o.val = 32'sh7fff_ffff;
        end
        else if (v < -51'sd2147483648)
        begin
            o.hit = 1'b1;
            o.val = 32'sh8000_0000;
        end
        return o;
    endfunction

    assign slot_ext = {7'd0, slot_mod_reg};
    assign p00 = par_reg[191:160];
    assign p10 = par_reg[159:128];
    assign p01 = par_reg[127:96];
    assign p11 = par_reg[95:64];
    assign ptx = par_reg[63:32];
    assign pty = par_reg[31:0];

    // select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            hatc_pkg::MUL_X:
            begin
                mul_a = {19'd0, rf_reg};
                mul_b = hatc_pkg::HALF_PI_Q30;
            end
            hatc_pkg::MUL_X2:
            begin
                mul_a = {3'd0, x_reg};
                mul_b = {3'd0, x_reg};
            end
            hatc_pkg::MUL_V:
            begin
                mul_a = {3'd0, x2_reg};
                mul_b = {2'd0, t_reg};
            end
            hatc_pkg::MUL_Q:
            begin
                mul_a = {3'd0, v_reg};
                mul_b = {3'd0, hatc_pkg::horner_m(cmd.mul_idx[2:0])};
            end
            hatc_pkg::MUL_S:
            begin
                mul_a = {3'd0, x_reg};
                mul_b = {2'd0, t_reg};
            end
            hatc_pkg::MUL_L:
            begin
                case (cmd.mul_idx[1:0])
                    2'd0:
                    begin
                        mul_a = 33'(sx_reg);
                        mul_b = 33'(cs_reg);
                    end
                    2'd1:
                    begin
                        mul_a = 33'(sx_reg);
                        mul_b = 33'(sn_reg);
                    end
                    2'd2:
                    begin
                        mul_a = -33'(sy_reg);
                        mul_b = 33'(sn_reg);
                    end
                    default:
                    begin
                        mul_a = 33'(sy_reg);
                        mul_b = 33'(cs_reg);
                    end
                endcase
            end
            hatc_pkg::MUL_C:
            begin
                case (cmd.mul_idx)
                    4'd0:    begin mul_a = 33'(p00); mul_b = 33'(loc_reg[0]); end
                    4'd1:    begin mul_a = 33'(p01); mul_b = 33'(loc_reg[1]); end
                    4'd2:    begin mul_a = 33'(p10); mul_b = 33'(loc_reg[0]); end
                    4'd3:    begin mul_a = 33'(p11); mul_b = 33'(loc_reg[1]); end
                    4'd4:    begin mul_a = 33'(p00); mul_b = 33'(loc_reg[2]); end
                    4'd5:    begin mul_a = 33'(p01); mul_b = 33'(loc_reg[3]); end
                    4'd6:    begin mul_a = 33'(p10); mul_b = 33'(loc_reg[2]); end
                    4'd7:    begin mul_a = 33'(p11); mul_b = 33'(loc_reg[3]); end
                    4'd8:    begin mul_a = 33'(p00); mul_b = 33'(px_reg); end
                    4'd9:    begin mul_a = 33'(p01); mul_b = 33'(py_reg); end
                    4'd10:   begin mul_a = 33'(p10); mul_b = 33'(px_reg); end
                    default: begin mul_a = 33'(p11); mul_b = 33'(py_reg); end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mres = mul_a * mul_b;

    // Horner correction, rounding and clamp helpers
    always_comb
    begin
        k_val   = hatc_pkg::horner_k(cmd.mul_idx[2:0]);
        qk      = 37'(q0_reg) * 37'(k_val);
        rem     = 31'(v_reg) - 31'(qk);
        qv      = 31'(q0_reg) + 31'(rem >= 31'(k_val));

        bs      = 17'((31'(s_reg) + 31'd8192) >> 14);
        bc      = 17'((32'(c_reg) + 32'd8192) >> 14);
        bs_sw   = swap_reg ? bc : bs;
        bc_sw   = swap_reg ? bs : bc;

        rl      = (prod_reg + 66'sd32768) >>> 16;
        l_res   = sat32(rl[50:0]);
        l_sat   = 33'(l_res.val);
        sum     = (acc_reg + prod_reg + 66'sd32768) >>> 16;

        case (cmd.fin_idx)
            3'd4:    fin_add = ptx;
            3'd5:    fin_add = pty;
            default: fin_add = '0;
        endcase
        fin_v   = 51'(rnd_reg) + 51'(fin_add);
        f_res   = sat32(fin_v);
        fin_sat = 33'(f_res.val);
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_raw_reg  <= slot_index;
            par_raw_reg   <= parent_slot;
            root_reg      <= is_root;
            quad_reg      <= angle[15:14];
            swap_reg      <= (angle[13:0] > 14'd8192);
            rf_reg        <= (angle[13:0] > 14'd8192) ? 14'(15'd16384 - 15'(angle[13:0]))
                                                      : angle[13:0];
            sx_reg        <= scale_x;
            sy_reg        <= scale_y;
            px_reg        <= pos_x;
            py_reg        <= pos_y;
            loc_flag_reg  <= 1'b0;
            comp_flag_reg <= 1'b0;
        end

        // multiplier results
        if (cmd.mul_op != hatc_pkg::MUL_NONE)
            prod_reg <= mres;
        case (cmd.mul_op)
            hatc_pkg::MUL_X2: x2_reg <= mres[59:30];
            hatc_pkg::MUL_V:  v_reg  <= mres[59:30];
            hatc_pkg::MUL_Q:  q0_reg <= mres[61:32];
            hatc_pkg::MUL_S:
            begin
                s_reg <= mres[59:30];
                t_reg <= hatc_pkg::ONE_Q30;
            end
            default: ;
        endcase

        // writebacks
        case (cmd.wb_op)
            hatc_pkg::WB_MOD:
            begin
                slot_mod_reg <= 10'(mod_nodes(slot_raw_reg));
                par_addr_reg <= AW'(mod_nodes(par_raw_reg));
            end
            hatc_pkg::WB_X:
            begin
                x_reg <= 30'((46'(prod_reg[43:0]) + 46'd8192) >> 14);
                t_reg <= hatc_pkg::ONE_Q30;
            end
            hatc_pkg::WB_CORR: t_reg <= hatc_pkg::ONE_Q30 - qv;
            hatc_pkg::WB_CFIN: c_reg <= hatc_pkg::ONE_Q30 - 31'(v_reg >> 1);
            hatc_pkg::WB_SC:
            begin
                case (quad_reg)
                    2'd0:
                    begin
                        sn_reg <= $signed({1'b0, bs_sw});
                        cs_reg <= $signed({1'b0, bc_sw});
                    end
                    2'd1:
                    begin
                        sn_reg <= $signed({1'b0, bc_sw});
                        cs_reg <= -$signed({1'b0, bs_sw});
                    end
                    2'd2:
                    begin
                        sn_reg <= -$signed({1'b0, bs_sw});
                        cs_reg <= -$signed({1'b0, bc_sw});
                    end
                    default:
                    begin
                        sn_reg <= -$signed({1'b0, bc_sw});
                        cs_reg <= $signed({1'b0, bs_sw});
                    end
                endcase
            end
            hatc_pkg::WB_L:
            begin
                loc_reg[cmd.wb_idx[1:0]] <= l_sat[31:0];
                loc_flag_reg             <= loc_flag_reg | l_res.hit;
            end
            hatc_pkg::WB_LOAD: acc_reg <= prod_reg;
            hatc_pkg::WB_ADD:  rnd_reg <= sum[49:0];
            hatc_pkg::WB_FINAL:
            begin
                if (root_reg)
                begin
                    res_reg[0] <= loc_reg[0];
                    res_reg[1] <= loc_reg[1];
                    res_reg[2] <= loc_reg[2];
                    res_reg[3] <= loc_reg[3];
                    res_reg[4] <= px_reg;
                    res_reg[5] <= py_reg;
                    res_flag_reg <= loc_flag_reg;
                end
                else
                begin
                    res_reg <= comp_reg;
                    res_flag_reg <= loc_flag_reg | comp_flag_reg;
                end
            end
            default: ;
        endcase

        // clamp a composed entry
        if (cmd.fin_en)
        begin
            comp_reg[cmd.fin_idx] <= fin_sat[31:0];
            comp_flag_reg         <= comp_flag_reg | f_res.hit;
        end

        // present result
        if (cmd.load_out)
        begin
            out_slot_reg <= slot_mod_reg;
            out_m_reg    <= res_reg;
            out_flag_reg <= res_flag_reg;
        end
    end

    // global matrix store: read parent, write own slot
    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
            par_reg <= mem[par_addr_reg];
        if (cmd.mem_wr)
            mem[slot_ext[AW-1:0]] <= {res_reg[0], res_reg[1], res_reg[2],
                                      res_reg[3], res_reg[4], res_reg[5]};
    end

    assign out_slot  = out_slot_reg;
    assign m00       = out_m_reg[0];
    assign m10       = out_m_reg[1];
    assign m01       = out_m_reg[2];
    assign m11       = out_m_reg[3];
    assign trans_x   = out_m_reg[4];
    assign trans_y   = out_m_reg[5];
    assign saturated = out_flag_reg;

endmodule
